// ----- design/bba_pkg.sv -----
`timescale 1ns / 1ps
package bba_pkg;
	localparam int MAX_BLOCKS = 8192;
	localparam int MAP_BYTES  = MAX_BLOCKS / 8;
	localparam int BYTE_AW    = $clog2(MAP_BYTES);
	localparam int CNT_W      = 14;
	localparam int MODE_W     = 2;
	localparam int STAT_W     = 2;

	localparam logic [MODE_W-1:0] MODE_ALLOC = 2'd0;
	localparam logic [MODE_W-1:0] MODE_MARK  = 2'd1;
	localparam logic [MODE_W-1:0] MODE_FREE  = 2'd2;
	localparam logic [MODE_W-1:0] MODE_QUERY = 2'd3;

	localparam logic [STAT_W-1:0] STAT_OK       = 2'd0;
	localparam logic [STAT_W-1:0] STAT_NO_SPACE = 2'd1;
	localparam logic [STAT_W-1:0] STAT_NOT_FOUND = 2'd2;

	localparam logic [CNT_W-1:0] MAX_COUNT = CNT_W'(MAX_BLOCKS);
endpackage

// ----- design/bba_req_if.sv -----
`timescale 1ns / 1ps
interface bba_req_if;
	logic                      valid;
	logic                      ready;
	logic [bba_pkg::MODE_W-1:0] mode;
	logic [bba_pkg::CNT_W-1:0]  block_index;

	modport source (output valid, output mode, output block_index, input ready);
	modport sink (input valid, input mode, input block_index, output ready);
endinterface

// ----- design/bba_rsp_if.sv -----
`timescale 1ns / 1ps
interface bba_rsp_if;
	logic                       valid;
	logic                       ready;
	logic [bba_pkg::STAT_W-1:0] status;
	logic [bba_pkg::CNT_W-1:0]  allocated_index;
	logic                       was_used;
	logic [bba_pkg::CNT_W-1:0]  free_left;

	modport source (output valid, output status, output allocated_index, output was_used,
		output free_left, input ready);
	modport sink (input valid, input status, input allocated_index, input was_used,
		input free_left, output ready);
endinterface

// ----- design/block_bitmap_allocator.sv -----
`timescale 1ns / 1ps
// Mark used, mark free and query: the map byte is read, then the result is registered in the RMW state;
// a bad block number, or allocate with a zero counter or no reachable byte, answers at once.
// Allocate: the scan reads the map bytes in order from byte 0; the first byte with a free bit
// gets its lowest free bit set and answers; a full map answers no space after the reachable bytes.
// One request at a time; the next one is taken in idle while no result waits or it is being accepted.
// Reset and every block_count write clear the 1024-byte map, one byte per cycle.
module block_bitmap_allocator (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_we,
	input  logic [bba_pkg::CNT_W-1:0] cfg_wdata,
	bba_req_if.sink                   req,
	bba_rsp_if.source                 rsp
);
	localparam logic [1:0] S_CLEAR = 2'd0;
	localparam logic [1:0] S_IDLE  = 2'd1;
	localparam logic [1:0] S_SCAN  = 2'd2;
	localparam logic [1:0] S_RMW   = 2'd3;

	localparam int AW = bba_pkg::BYTE_AW;
	localparam int CW = bba_pkg::CNT_W;

	logic [1:0]                    state_q, state_d;
	logic [CW-1:0]                 eff_q;
	logic [CW-1:0]                 free_q, free_d;
	logic [AW-1:0]                 clr_addr_q;
	logic [AW:0]                   issue_q, issue_d;
	logic                          pend_s1, pend_d;
	logic [AW-1:0]                 pend_addr_s1;
	logic [AW-1:0]                 op_addr_q;
	logic [2:0]                    op_bit_q;
	logic [bba_pkg::MODE_W-1:0]    op_mode_q;

	logic [7:0]                    map_mem [bba_pkg::MAP_BYTES];
	logic                          mem_we, mem_re;
	logic [AW-1:0]                 mem_wa, mem_ra;
	logic [7:0]                    mem_wd, rd_data_s1;

	logic                          rsp_valid_q;
	logic [bba_pkg::STAT_W-1:0]    rsp_status_q, rsp_status_d;
	logic [CW-1:0]                 rsp_alloc_q, rsp_alloc_d;
	logic                          rsp_used_q, rsp_used_d;
	logic [CW-1:0]                 rsp_free_q;
	logic                          rsp_load;

	logic                          accept;
	logic [AW:0]                   nbytes;
	logic [CW-1:0]                 reach_max;
	logic [CW-1:0]                 pos;
	logic                          num_ok;
	logic                          found;
	logic [2:0]                    free_bit;
	logic [CW-1:0]                 cfg_eff;

	assign nbytes    = eff_q[CW-1:3];
	assign reach_max = {eff_q[CW-1:3], 3'b000};
	assign pos       = req.block_index - CW'(1);
	assign num_ok    = (req.block_index != '0) && (req.block_index <= reach_max);
	assign cfg_eff   = (cfg_wdata > bba_pkg::MAX_COUNT) ? bba_pkg::MAX_COUNT : cfg_wdata;

	assign req.ready = (state_q == S_IDLE) && (!rsp_valid_q || rsp.ready);
	assign accept    = req.valid && req.ready;

	always_comb begin
		free_bit = 3'd0;
		for (int k = 7; k >= 0; k--) begin
			if (!rd_data_s1[k]) begin
				free_bit = 3'(k);
			end
		end
	end

	assign found = pend_s1 && (rd_data_s1 != 8'hFF);

	always_comb begin
		state_d      = state_q;
		free_d       = free_q;
		issue_d      = issue_q;
		pend_d       = 1'b0;
		mem_we       = 1'b0;
		mem_wa       = clr_addr_q;
		mem_wd       = 8'h00;
		mem_re       = 1'b0;
		mem_ra       = pos[AW+2:3];
		rsp_load     = 1'b0;
		rsp_status_d = bba_pkg::STAT_OK;
		rsp_alloc_d  = '0;
		rsp_used_d   = 1'b0;
		case (state_q)
			S_CLEAR: begin
				mem_we = 1'b1;
				if (clr_addr_q == AW'(bba_pkg::MAP_BYTES - 1)) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (accept) begin
					if (req.mode == bba_pkg::MODE_ALLOC) begin
						if (free_q == '0 || nbytes == '0) begin
							rsp_load     = 1'b1;
							rsp_status_d = bba_pkg::STAT_NO_SPACE;
						end else begin
							state_d = S_SCAN;
							issue_d = '0;
						end
					end else if (!num_ok) begin
						rsp_load     = 1'b1;
						rsp_status_d = bba_pkg::STAT_NOT_FOUND;
					end else begin
						mem_re  = 1'b1;
						state_d = S_RMW;
					end
				end
			end
			S_SCAN: begin
				mem_ra = issue_q[AW-1:0];
				if (found) begin
					mem_we      = 1'b1;
					mem_wa      = pend_addr_s1;
					mem_wd      = rd_data_s1 | (8'h01 << free_bit);
					free_d      = free_q - CW'(1);
					rsp_load    = 1'b1;
					rsp_alloc_d = CW'({pend_addr_s1, free_bit}) + CW'(1);
					state_d     = S_IDLE;
				end else if (issue_q >= nbytes) begin
					rsp_load     = 1'b1;
					rsp_status_d = bba_pkg::STAT_NO_SPACE;
					state_d      = S_IDLE;
				end else begin
					mem_re  = 1'b1;
					pend_d  = 1'b1;
					issue_d = issue_q + (AW+1)'(1);
				end
			end
			S_RMW: begin
				mem_wa   = op_addr_q;
				rsp_load = 1'b1;
				state_d  = S_IDLE;
				case (op_mode_q)
					bba_pkg::MODE_MARK: begin
						mem_we = 1'b1;
						mem_wd = rd_data_s1 | (8'h01 << op_bit_q);
						if (free_q != '0) begin
							free_d = free_q - CW'(1);
						end
					end
					bba_pkg::MODE_FREE: begin
						mem_we = 1'b1;
						mem_wd = rd_data_s1 & ~(8'h01 << op_bit_q);
						if (free_q < eff_q) begin
							free_d = free_q + CW'(1);
						end
					end
					default: begin
						rsp_used_d = rd_data_s1[op_bit_q];
					end
				endcase
			end
			default: begin
				state_d = S_CLEAR;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			map_mem[mem_wa] <= mem_wd;
		end
		if (mem_re) begin
			rd_data_s1 <= map_mem[mem_ra];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			eff_q       <= bba_pkg::MAX_COUNT;
			free_q      <= bba_pkg::MAX_COUNT;
			clr_addr_q  <= '0;
			issue_q     <= '0;
			pend_s1     <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				state_q    <= S_CLEAR;
				eff_q      <= cfg_eff;
				free_q     <= cfg_eff;
				clr_addr_q <= '0;
				pend_s1    <= 1'b0;
			end else begin
				state_q    <= state_d;
				free_q     <= free_d;
				clr_addr_q <= (state_q == S_CLEAR) ? clr_addr_q + AW'(1) : '0;
				pend_s1    <= pend_d;
			end
			issue_q <= issue_d;
			if (rsp_load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pend_d) begin
			pend_addr_s1 <= issue_q[AW-1:0];
		end
		if (accept) begin
			op_addr_q <= pos[AW+2:3];
			op_bit_q  <= pos[2:0];
			op_mode_q <= req.mode;
		end
		if (rsp_load) begin
			rsp_status_q <= rsp_status_d;
			rsp_alloc_q  <= rsp_alloc_d;
			rsp_used_q   <= rsp_used_d;
			rsp_free_q   <= free_d;
		end
	end

	assign rsp.valid           = rsp_valid_q;
	assign rsp.status          = rsp_status_q;
	assign rsp.allocated_index = rsp_alloc_q;
	assign rsp.was_used        = rsp_used_q;
	assign rsp.free_left       = rsp_free_q;
endmodule

// ----- design/bba_checker.sv -----
`timescale 1ns / 1ps
module bba_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        cfg_we,
	input logic                        req_ready,
	input logic                        rsp_valid,
	input logic                        rsp_ready,
	input logic [bba_pkg::STAT_W-1:0]  rsp_status,
	input logic [bba_pkg::CNT_W-1:0]   rsp_allocated_index,
	input logic                        rsp_was_used,
	input logic [bba_pkg::CNT_W-1:0]   rsp_free_left
);
	// hold a stalled result
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status)
			&& $stable(rsp_allocated_index) && $stable(rsp_free_left))
		else $error("stalled result changed");

	a_err_fields: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_status != bba_pkg::STAT_OK |-> rsp_allocated_index == '0
			&& !rsp_was_used)
		else $error("failed request carries data");

	a_free_bound: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> rsp_free_left <= bba_pkg::MAX_COUNT)
		else $error("free count above limit");

	a_cfg_clear: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_we |=> !req_ready)
		else $error("request taken during map clear");
endmodule

bind block_bitmap_allocator bba_checker u_bba_checker (
	.clk                 (clk),
	.arst_n              (arst_n),
	.cfg_we              (cfg_we),
	.req_ready           (req.ready),
	.rsp_valid           (rsp.valid),
	.rsp_ready           (rsp.ready),
	.rsp_status          (rsp.status),
	.rsp_allocated_index (rsp.allocated_index),
	.rsp_was_used        (rsp.was_used),
	.rsp_free_left       (rsp.free_left)
);
